>>> design/gcmr_pkg.sv
// Shared types and constants for the masked-register GPIO controller.
`timescale 1ns / 1ps

package gcmr_pkg;

    localparam int NUM_BANKS      = 8;
    localparam int PORTS_PER_BANK = 4;
    localparam int PORT_SLOTS     = NUM_BANKS * PORTS_PER_BANK;
    localparam int ROW_W          = 32;

    localparam logic [3:0] GRP_CNF = 4'h0;
    localparam logic [3:0] GRP_OE  = 4'h1;
    localparam logic [3:0] GRP_OUT = 4'h2;
    localparam logic [3:0] GRP_IN  = 4'h3;
    localparam logic [3:0] GRP_INT = 4'h5;

    // byte lanes of one stored row
    localparam logic [1:0] LANE_CNF = 2'd0;
    localparam logic [1:0] LANE_OE  = 2'd1;
    localparam logic [1:0] LANE_OUT = 2'd2;
    localparam logic [1:0] LANE_INT = 2'd3;

    localparam logic [1:0] CFG_BANK_PITCH    = 2'd0;
    localparam logic [1:0] CFG_ALIAS_BASE    = 2'd1;
    localparam logic [1:0] CFG_BANKS_PRESENT = 2'd2;

    localparam logic [8:0]  BANK_PITCH_RST    = 9'h080;
    localparam logic [11:0] ALIAS_BASE_RST    = 12'h800;
    localparam logic [3:0]  BANKS_PRESENT_RST = 4'd7;

    typedef struct packed {
        logic        mode;
        logic [11:0] address;
        logic [15:0] write_data;
        logic [7:0]  pin_levels;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       addr_error;
        logic [4:0] port_index;
        logic [7:0] port_gpio_mode;
        logic [7:0] port_drive_enable;
        logic [7:0] port_drive_value;
    } rsp_t;

    typedef struct packed {
        logic       err;
        logic       masked;
        logic       is_in;
        logic [1:0] lane;
        logic [4:0] idx;
    } dec_t;

endpackage

>>> design/gcmr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module gcmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/gcmr_decode.sv
// Address decode: bank, port, register group, alias and error detection.
`timescale 1ns / 1ps

module gcmr_decode
    import gcmr_pkg::*;
(
    input  logic [11:0] address,
    input  logic [8:0]  bank_pitch,
    input  logic [11:0] alias_base,
    input  logic [3:0]  banks_present,
    output dec_t        dec
);

    logic        wide;
    logic        upper_low;
    logic [11:0] base;
    logic [4:0]  bank;
    logic [7:0]  local_off;
    logic [3:0]  grp;
    logic        masked;
    logic        grp_ok;
    logic        bank_ok;

    always_comb
    begin
        wide      = bank_pitch[8];
        upper_low = wide ? (alias_base < 12'h100) : (alias_base < 12'h080);
        masked    = 1'b0;
        base      = address;
        if (!upper_low && address >= alias_base)
        begin
            masked = 1'b1;
            base   = address - alias_base;
        end
        bank      = wide ? {1'b0, base[11:8]} : base[11:7];
        local_off = wide ? base[7:0] : {1'b0, base[6:0]};
        if (upper_low && {4'b0, local_off} >= alias_base)
        begin
            masked    = 1'b1;
            local_off = local_off - alias_base[7:0];
        end

        grp     = local_off[7:4];
        grp_ok  = (grp == GRP_CNF) || (grp == GRP_OE) || (grp == GRP_OUT)
               || (grp == GRP_IN) || (grp == GRP_INT);
        bank_ok = (bank < {1'b0, banks_present}) && (bank < 5'(NUM_BANKS));

        dec.err    = (local_off[1:0] != 2'b00) || !grp_ok || !bank_ok
                  || (masked && !((grp == GRP_CNF) || (grp == GRP_OE) || (grp == GRP_OUT)));
        dec.masked = masked;
        dec.is_in  = (grp == GRP_IN);
        dec.idx    = {bank[2:0], local_off[3:2]};
        unique case (grp)
            GRP_OE:  dec.lane = LANE_OE;
            GRP_OUT: dec.lane = LANE_OUT;
            GRP_INT: dec.lane = LANE_INT;
            default: dec.lane = LANE_CNF;
        endcase
    end

endmodule

>>> design/gcmr_rmw.sv
// Read-modify-write of one port row and formation of the result item.
`timescale 1ns / 1ps

module gcmr_rmw
    import gcmr_pkg::*;
(
    input  dec_t             dec,
    input  logic             mode,
    input  logic [15:0]      write_data,
    input  logic [7:0]       pin_levels,
    input  logic [ROW_W-1:0] old_row,
    output logic             row_we,
    output logic [ROW_W-1:0] new_row,
    output rsp_t             rsp
);

    logic [7:0] old_byte;
    logic [7:0] mask;
    logic [7:0] new_byte;

    always_comb
    begin
        old_byte = old_row[dec.lane*8 +: 8];
        mask     = dec.masked ? write_data[15:8] : 8'hFF;
        new_byte = (old_byte & ~mask) | (write_data[7:0] & mask);
        row_we   = !dec.err && mode && !dec.is_in;
        new_row  = old_row;
        if (row_we)
        begin
            new_row[dec.lane*8 +: 8] = new_byte;
        end

        if (dec.err)
        begin
            rsp = '0;
            rsp.addr_error = 1'b1;
        end
        else
        begin
            rsp.read_data         = mode ? 8'h00 : (dec.is_in ? pin_levels : old_byte);
            rsp.addr_error        = 1'b0;
            rsp.port_index        = dec.idx;
            rsp.port_gpio_mode    = new_row[LANE_CNF*8 +: 8];
            rsp.port_drive_enable = new_row[LANE_OE*8 +: 8];
            rsp.port_drive_value  = new_row[LANE_OUT*8 +: 8];
        end
    end

endmodule

>>> design/gpio_controller_masked_regs.sv
// Top level of the GPIO controller with masked-write alias registers.
// Timing: done is high in the cycle after the work cycle, together with the
// registered response.
// Flow: the port-row RAM read is done at the accepting edge, then the modify and
// write-back in the work cycle, while busy is high and no new item is accepted.
// Reset: registers to 128 / 2048 / 7, all port rows read as zero via per-row valid bits.
`timescale 1ns / 1ps

module gpio_controller_masked_regs
    import gcmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output rsp_t        response,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic [8:0]            bank_pitch_reg;
    logic [11:0]           alias_base_reg;
    logic [3:0]            banks_present_reg;
    logic                  busy_reg;
    logic                  done_reg;
    rsp_t                  rsp_reg;
    dec_t                  dec_reg;
    logic                  mode_reg;
    logic [15:0]           wdata_reg;
    logic [7:0]            pins_reg;
    logic [PORT_SLOTS-1:0] valid_reg;
    logic [PORT_SLOTS-1:0] valid_next;

    dec_t             dec;
    logic             accept;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] old_row;
    logic             row_we;
    logic [ROW_W-1:0] new_row;
    rsp_t             rsp;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign response = rsp_reg;

    gcmr_decode u_decode (
        .address       (request.address),
        .bank_pitch    (bank_pitch_reg),
        .alias_base    (alias_base_reg),
        .banks_present (banks_present_reg),
        .dec           (dec)
    );

    gcmr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PORT_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (busy_reg && row_we),
        .waddr (dec_reg.idx),
        .wdata (new_row),
        .raddr (dec.idx),
        .rdata (ram_rdata)
    );

    assign old_row = valid_reg[dec_reg.idx] ? ram_rdata : '0;

    gcmr_rmw u_rmw (
        .dec        (dec_reg),
        .mode       (mode_reg),
        .write_data (wdata_reg),
        .pin_levels (pins_reg),
        .old_row    (old_row),
        .row_we     (row_we),
        .new_row    (new_row),
        .rsp        (rsp)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (busy_reg && row_we)
        begin
            valid_next[dec_reg.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_pitch_reg    <= BANK_PITCH_RST;
            alias_base_reg    <= ALIAS_BASE_RST;
            banks_present_reg <= BANKS_PRESENT_RST;
            busy_reg          <= 1'b0;
            done_reg          <= 1'b0;
            valid_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BANK_PITCH:    bank_pitch_reg    <= cfg_data[8:0];
                    CFG_ALIAS_BASE:    alias_base_reg    <= cfg_data;
                    CFG_BANKS_PRESENT: banks_present_reg <= cfg_data[3:0];
                    default:           ;
                endcase
            end
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg   <= dec;
            mode_reg  <= request.mode;
            wdata_reg <= request.write_data;
            pins_reg  <= request.pin_levels;
        end
        if (busy_reg)
        begin
            rsp_reg <= rsp;
        end
    end

`ifndef ASSERT_OFF
    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("result strobe without work cycle");

    a_single_work_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("work cycle longer than one cycle");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.addr_error) |->
            (response.read_data == 8'h00 && response.port_index == 5'd0))
        else $error("error result carries data");
`endif

endmodule

>>> verif/tb_gpio_controller_masked_regs.sv
// Testbench for the masked-register GPIO controller: directed and random bus accesses.
`timescale 1ns / 1ps

module tb_gpio_controller_masked_regs;

    import gcmr_pkg::*;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;
    localparam int   STALL_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        response;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    // predictor state
    logic [7:0]  gpio_mode_q   [PORT_SLOTS];
    logic [7:0]  drive_en_q    [PORT_SLOTS];
    logic [7:0]  drive_val_q   [PORT_SLOTS];
    logic [7:0]  irq_en_q      [PORT_SLOTS];
    logic [8:0]  bank_pitch_q;
    logic [11:0] alias_base_q;
    logic [3:0]  banks_present_q;

    rsp_t pending_responses[$];
    int   fail_count;
    int   stall_cycles;
    int   sender_idle_pct;

    gpio_controller_masked_regs DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t predict_access(req_t r);
        int unsigned span;
        int unsigned bank;
        int unsigned offs;
        int unsigned grp;
        int unsigned slot;
        logic        alias_hit;
        logic        bad;
        logic [7:0]  v;
        logic [7:0]  m;
        rsp_t        rsp;
        span = bank_pitch_q[8] ? 256 : 128;
        alias_hit = 1'b0;
        if (alias_base_q < span)
        begin
            bank = r.address / span;
            offs = r.address % span;
            if (offs >= alias_base_q)
            begin
                alias_hit = 1'b1;
                offs = offs - alias_base_q;
            end
        end
        else
        begin
            offs = r.address;
            if (r.address >= alias_base_q)
            begin
                alias_hit = 1'b1;
                offs = r.address - alias_base_q;
            end
            bank = offs / span;
            offs = offs % span;
        end
        grp = offs >> 4;
        bad = (offs % 4) != 0;
        if (grp != GRP_CNF && grp != GRP_OE && grp != GRP_OUT && grp != GRP_IN && grp != GRP_INT)
            bad = 1'b1;
        if (alias_hit && grp != GRP_CNF && grp != GRP_OE && grp != GRP_OUT)
            bad = 1'b1;
        if (bank >= banks_present_q || bank >= NUM_BANKS)
            bad = 1'b1;
        rsp = '0;
        if (bad)
        begin
            rsp.addr_error = 1'b1;
            return rsp;
        end
        slot = (bank * PORTS_PER_BANK + ((offs >> 2) % 4)) % PORT_SLOTS;
        if (r.mode == ACC_WRITE)
        begin
            v = r.write_data[7:0];
            m = alias_hit ? r.write_data[15:8] : 8'hFF;
            case (grp)
                GRP_CNF: gpio_mode_q[slot] = (gpio_mode_q[slot] & ~m) | (v & m);
                GRP_OE:  drive_en_q[slot]  = (drive_en_q[slot] & ~m) | (v & m);
                GRP_OUT: drive_val_q[slot] = (drive_val_q[slot] & ~m) | (v & m);
                GRP_INT: irq_en_q[slot]    = (irq_en_q[slot] & ~m) | (v & m);
                default: ;
            endcase
        end
        else
        begin
            case (grp)
                GRP_CNF: rsp.read_data = gpio_mode_q[slot];
                GRP_OE:  rsp.read_data = drive_en_q[slot];
                GRP_OUT: rsp.read_data = drive_val_q[slot];
                GRP_INT: rsp.read_data = irq_en_q[slot];
                default: rsp.read_data = r.pin_levels;
            endcase
        end
        rsp.port_index        = slot[4:0];
        rsp.port_gpio_mode    = gpio_mode_q[slot];
        rsp.port_drive_enable = drive_en_q[slot];
        rsp.port_drive_value  = drive_val_q[slot];
        return rsp;
    endfunction

    task automatic send_item(logic kind, logic [11:0] addr, logic [15:0] wdata,
                             logic [7:0] pins);
        req_t r;
        r.mode       = kind;
        r.address    = addr;
        r.write_data = wdata;
        r.pin_levels = pins;
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_responses.push_back(predict_access(r));
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic report(string what, int unsigned exp, int unsigned act);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp, act);
    endtask

    always @(posedge clk)
    begin
        rsp_t exp;
        if (done)
        begin
            if (pending_responses.size() == 0)
                report("unexpected result, addr_error", 0, response.addr_error);
            else
            begin
                exp = pending_responses.pop_front();
                if (response.read_data != exp.read_data)
                    report("read_data", exp.read_data, response.read_data);
                if (response.addr_error != exp.addr_error)
                    report("addr_error", exp.addr_error, response.addr_error);
                if (response.port_index != exp.port_index)
                    report("port_index", exp.port_index, response.port_index);
                if (response.port_gpio_mode != exp.port_gpio_mode)
                    report("port_gpio_mode", exp.port_gpio_mode, response.port_gpio_mode);
                if (response.port_drive_enable != exp.port_drive_enable)
                    report("port_drive_enable", exp.port_drive_enable,
                           response.port_drive_enable);
                if (response.port_drive_value != exp.port_drive_value)
                    report("port_drive_value", exp.port_drive_value,
                           response.port_drive_value);
            end
        end
    end

    // watchdog on cycles with no item accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic apply_settings(logic [11:0] stride, logic [11:0] upper, logic [11:0] count);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BANK_PITCH;
        cfg_data  <= stride;
        @(posedge clk);
        cfg_index <= CFG_ALIAS_BASE;
        cfg_data  <= upper;
        @(posedge clk);
        cfg_index <= CFG_BANKS_PRESENT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        bank_pitch_q    = stride[8:0];
        alias_base_q    = upper;
        banks_present_q = count[3:0];
    endtask

    // reset settings: stride 128, aliases at 0x800, banks 0..6
    task automatic test_directed();
        send_item(ACC_WRITE, 12'h000, 16'hFFA5, 8'h00);
        send_item(ACC_READ,  12'h000, 16'h0000, 8'h00);
        send_item(ACC_WRITE, 12'h014, 16'h00FF, 8'hFF);
        send_item(ACC_WRITE, 12'h028, 16'h003C, 8'h00);
        send_item(ACC_WRITE, 12'h05C, 16'h0081, 8'h00);
        send_item(ACC_READ,  12'h05C, 16'hFFFF, 8'h00);
        send_item(ACC_READ,  12'h030, 16'h0000, 8'hFF);
        send_item(ACC_WRITE, 12'h030, 16'hFFFF, 8'h00);
        send_item(ACC_WRITE, 12'h800, 16'h0F00, 8'h00);
        send_item(ACC_WRITE, 12'h814, 16'hF00F, 8'h00);
        send_item(ACC_WRITE, 12'h828, 16'hFF55, 8'h00);
        send_item(ACC_READ,  12'h800, 16'h0000, 8'h5A);
        send_item(ACC_WRITE, 12'h830, 16'hFFFF, 8'h00);
        send_item(ACC_READ,  12'h85C, 16'h0000, 8'h00);
        send_item(ACC_READ,  12'h001, 16'h0000, 8'h00);
        send_item(ACC_WRITE, 12'h002, 16'h00FF, 8'h00);
        send_item(ACC_READ,  12'h040, 16'h0000, 8'h00);
        send_item(ACC_WRITE, 12'h060, 16'h00FF, 8'h00);
        send_item(ACC_READ,  12'h07C, 16'h0000, 8'h00);
        send_item(ACC_WRITE, 12'h380, 16'hFFFF, 8'h00);
        send_item(ACC_WRITE, 12'h368, 16'h00FF, 8'h00);
        send_item(ACC_READ,  12'h368, 16'h0000, 8'h00);
        send_item(ACC_READ,  12'hFFF, 16'h0000, 8'hFF);
        send_item(ACC_WRITE, 12'h090, 16'h0000, 8'h00);
        send_item(ACC_READ,  12'h7FC, 16'h0000, 8'h00);
    endtask

    // mostly well-formed accesses in the present map, some raw noise
    task automatic test_random_traffic(int count);
        int unsigned span;
        int unsigned bank;
        int unsigned grp;
        int unsigned offs;
        int unsigned addr;
        logic        use_alias;
        span = bank_pitch_q[8] ? 256 : 128;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                addr = $urandom_range(0, 4095);
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    bank = $urandom_range(0, NUM_BANKS);
                else
                    bank = $urandom_range(0, banks_present_q - 1);
                case ($urandom_range(0, 5))
                    0: grp = GRP_CNF;
                    1: grp = GRP_OE;
                    2: grp = GRP_OUT;
                    3: grp = GRP_IN;
                    4: grp = GRP_INT;
                    default: grp = $urandom_range(0, 7);
                endcase
                offs = (grp << 4) | ($urandom_range(0, 3) << 2);
                if ($urandom_range(0, 11) == 0)
                    offs = offs | $urandom_range(1, 3);
                use_alias = 1'($urandom_range(0, 1));
                addr = (use_alias ? alias_base_q : 0) + bank * span + offs;
            end
            send_item(1'($urandom_range(0, 1)), addr[11:0], 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
            if ($urandom_range(0, 63) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BANK_PITCH;
        cfg_data  = '0;
        fail_count   = 0;
        stall_cycles = 0;
        sender_idle_pct = 25;
        for (int i = 0; i < PORT_SLOTS; i++)
        begin
            gpio_mode_q[i] = '0;
            drive_en_q[i]  = '0;
            drive_val_q[i] = '0;
            irq_en_q[i]    = '0;
        end
        bank_pitch_q    = BANK_PITCH_RST;
        alias_base_q    = ALIAS_BASE_RST;
        banks_present_q = BANKS_PRESENT_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(135);
        apply_settings(12'h100, 12'h080, 12'h8);
        test_random_traffic(135);

        sender_idle_pct = 56;
        apply_settings(12'h080, 12'h400, 12'h8);
        test_random_traffic(135);
        apply_settings(12'h100, 12'h100, 12'h5);
        test_random_traffic(135);

        sender_idle_pct = 0;
        apply_settings(12'h080, 12'h800, 12'h1);
        test_random_traffic(135);
        apply_settings(12'h100, 12'h800, 12'h8);
        test_random_traffic(135);
        apply_settings(12'h100, 12'h0C0, 12'h3);
        test_random_traffic(135);
        apply_settings(12'h080, 12'h080, 12'h4);
        test_random_traffic(135);

        wait_drained();
        repeat (6) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $display("%0d results never arrived", pending_responses.size());
            fail_count += pending_responses.size();
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
